// File: hw/rtl/hsd_pkg.sv
`default_nettype none

package hsd_pkg;

  localparam logic [15:0] SYL_BASE       = 16'hAC00;
  localparam logic [15:0] SYL_LAST_VALID = 16'hD7A3;
  localparam logic [15:0] SYL_END        = 16'hD7AF;
  localparam logic [15:0] CJ_INITIAL     = 16'h1100;
  localparam logic [15:0] CJ_INITIAL_HI  = 16'h1112;
  localparam logic [15:0] CJ_MEDIAL      = 16'h1161;
  localparam logic [15:0] CJ_MEDIAL_HI   = 16'h1175;
  localparam logic [15:0] CJ_FINAL       = 16'h11A8;
  localparam logic [15:0] CJ_FINAL_HI    = 16'h11C2;
  localparam logic [15:0] CONJ_HI        = 16'h11FF;
  localparam logic [15:0] COMPAT_LO      = 16'h3130;
  localparam logic [15:0] COMPAT_HI      = 16'h318F;
  localparam logic [15:0] COMPAT_VOWEL0  = 16'h314F;

  // syllable index = initial * 588 + medial * 28 + final
  localparam int unsigned PER_MEDIAL  = 28;
  localparam int unsigned PER_INITIAL = 21;  // medials per initial, in units of 28

  // floor(rel / 28) = (rel * RECIP28) >> SHIFT28, exact for rel < 11172
  localparam logic [13:0] RECIP28 = 14'd9363;
  localparam int unsigned SHIFT28 = 18;
  // floor(q / 21) = (q * RECIP21) >> SHIFT21, exact for q < 399
  localparam logic [8:0]  RECIP21 = 9'd391;
  localparam int unsigned SHIFT21 = 13;

  localparam int unsigned MAX_RESULTS = 4;

  typedef logic [15:0] code_t;
  typedef logic [2:0]  count_t;

  typedef struct packed {
    count_t                       count;
    logic                         bad;
    logic [MAX_RESULTS-1:0][15:0] codes;
  } dec_t;

  function automatic code_t initial_jamo(input logic [4:0] idx);
    code_t c;
    case (idx)
      5'd0:    c = 16'h3131;
      5'd1:    c = 16'h3132;
      5'd2:    c = 16'h3134;
      5'd3:    c = 16'h3137;
      5'd4:    c = 16'h3138;
      5'd5:    c = 16'h3139;
      5'd6:    c = 16'h3141;
      5'd7:    c = 16'h3142;
      5'd8:    c = 16'h3143;
      5'd9:    c = 16'h3145;
      5'd10:   c = 16'h3146;
      5'd11:   c = 16'h3147;
      5'd12:   c = 16'h3148;
      5'd13:   c = 16'h3149;
      5'd14:   c = 16'h314A;
      5'd15:   c = 16'h314B;
      5'd16:   c = 16'h314C;
      5'd17:   c = 16'h314D;
      default: c = 16'h314E;
    endcase
    return c;
  endfunction

  function automatic code_t final_jamo(input logic [4:0] idx);
    code_t c;
    case (idx)
      5'd0:    c = 16'h3131;
      5'd1:    c = 16'h3132;
      5'd2:    c = 16'h3133;
      5'd3:    c = 16'h3134;
      5'd4:    c = 16'h3135;
      5'd5:    c = 16'h3136;
      5'd6:    c = 16'h3137;
      5'd7:    c = 16'h3139;
      5'd8:    c = 16'h313A;
      5'd9:    c = 16'h313B;
      5'd10:   c = 16'h313C;
      5'd11:   c = 16'h313D;
      5'd12:   c = 16'h313E;
      5'd13:   c = 16'h313F;
      5'd14:   c = 16'h3140;
      5'd15:   c = 16'h3141;
      5'd16:   c = 16'h3142;
      5'd17:   c = 16'h3144;
      5'd18:   c = 16'h3145;
      5'd19:   c = 16'h3146;
      5'd20:   c = 16'h3147;
      5'd21:   c = 16'h3148;
      5'd22:   c = 16'h314A;
      5'd23:   c = 16'h314B;
      5'd24:   c = 16'h314C;
      5'd25:   c = 16'h314D;
      default: c = 16'h314E;
    endcase
    return c;
  endfunction

  // first vowel of a compound medial, zero for a simple one
  function automatic code_t split_first(input logic [4:0] med);
    code_t c;
    case (med)
      5'd9, 5'd10, 5'd11:  c = 16'h3157;
      5'd14, 5'd15, 5'd16: c = 16'h315C;
      5'd19:               c = 16'h3161;
      default:             c = 16'h0000;
    endcase
    return c;
  endfunction

  function automatic code_t split_second(input logic [4:0] med);
    code_t c;
    case (med)
      5'd9:                c = 16'h314F;
      5'd10:               c = 16'h3150;
      5'd14:               c = 16'h3153;
      5'd15:               c = 16'h3154;
      5'd11, 5'd16, 5'd19: c = 16'h3163;
      default:             c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hsd_decode.sv
`default_nettype none

module hsd_decode (
  input  wire logic [15:0] code,
  input  wire logic [8:0]  q28,   // syllable index / 28, precomputed at capture
  output hsd_pkg::dec_t    dec
);

  logic [13:0] rel;
  logic [13:0] fin_wide;
  logic [4:0]  fin;
  logic [17:0] ini_prod;
  logic [4:0]  ini;
  logic [8:0]  med_wide;
  logic [4:0]  med;
  logic [15:0] sf;
  logic [15:0] ss;
  logic [15:0] fcode;
  logic        compound;
  logic        has_fin;
  logic [15:0] conj_code;

  assign rel      = 14'(code - hsd_pkg::SYL_BASE);
  assign fin_wide = rel - 14'(q28) * 14'(hsd_pkg::PER_MEDIAL);
  assign fin      = fin_wide[4:0];
  assign ini_prod = 18'(q28) * 18'(hsd_pkg::RECIP21);
  assign ini      = ini_prod[hsd_pkg::SHIFT21 +: 5];
  assign med_wide = q28 - 9'(ini) * 9'(hsd_pkg::PER_INITIAL);
  assign med      = med_wide[4:0];

  assign sf       = hsd_pkg::split_first(med);
  assign ss       = hsd_pkg::split_second(med);
  assign fcode    = hsd_pkg::final_jamo(5'(fin - 5'd1));
  assign compound = (sf != 16'h0000);
  assign has_fin  = (fin != 5'd0);

  always_comb begin
    if (code inside {[hsd_pkg::CJ_INITIAL:hsd_pkg::CJ_INITIAL_HI]}) begin
      conj_code = hsd_pkg::initial_jamo(5'(code - hsd_pkg::CJ_INITIAL));
    end else if (code inside {[hsd_pkg::CJ_MEDIAL:hsd_pkg::CJ_MEDIAL_HI]}) begin
      conj_code = hsd_pkg::COMPAT_VOWEL0 + (code - hsd_pkg::CJ_MEDIAL);
    end else if (code inside {[hsd_pkg::CJ_FINAL:hsd_pkg::CJ_FINAL_HI]}) begin
      conj_code = hsd_pkg::final_jamo(5'(code - hsd_pkg::CJ_FINAL));
    end else begin
      conj_code = code;
    end
  end

  always_comb begin
    dec       = '0;
    dec.count = 3'd1;
    dec.codes[0] = code;
    if (code inside {[hsd_pkg::COMPAT_LO:hsd_pkg::COMPAT_HI]}) begin
      dec.codes[0] = code;
    end else if (code inside {[hsd_pkg::CJ_INITIAL:hsd_pkg::CONJ_HI]}) begin
      dec.codes[0] = conj_code;
    end else if (code < hsd_pkg::SYL_BASE || code > hsd_pkg::SYL_END) begin
      dec.codes[0] = code;
    end else if (code > hsd_pkg::SYL_LAST_VALID) begin
      dec.codes[0] = 16'h0000;
      dec.bad      = 1'b1;
    end else begin
      dec.codes[0] = hsd_pkg::initial_jamo(ini);
      dec.codes[1] = compound ? sf : hsd_pkg::COMPAT_VOWEL0 + 16'(med);
      dec.codes[2] = compound ? ss : fcode;
      dec.codes[3] = fcode;
      dec.count    = 3'd2 + 3'(compound) + 3'(has_fin);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hangul_syllable_decomposer_unit.sv
`default_nettype none

// Splits one 16-bit code point into compatibility jamo, one per cycle on the
// out_ strobe, with out_last_of_run on the final one. A Hangul syllable
// yields 2 to 4 jamo; every other code point yields one. A code point passes
// the input register, run buffer and output register before its first jamo
// appears; one taken while the run buffer holds more than its last jamo
// waits until that run is down to its last jamo, so its first jamo follows
// the previous run with no gap. The block takes code points only as fast as
// the single result port drains their 1 to 4 jamo. The receiver cannot
// stall; results are never held back once out_valid is shown.
module hangul_syllable_decomposer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_code_point,
  output logic             out_valid,
  output logic [15:0]      out_jamo_code,
  output logic             out_last_of_run,
  output logic             out_bad_syllable
);

  logic        accept;
  logic        load;
  logic        pop;

  logic [13:0] cap_rel;
  logic [27:0] cap_prod;

  logic        in_vld_r;
  logic        in_vld_nxt;
  logic [15:0] in_code_r;
  logic [8:0]  in_q28_r;

  hsd_pkg::dec_t dec;

  logic [hsd_pkg::MAX_RESULTS-1:0][15:0] buf_r;
  logic [hsd_pkg::MAX_RESULTS-1:0][15:0] buf_nxt;
  logic                                  buf_bad_r;
  logic                                  buf_bad_nxt;
  hsd_pkg::count_t                       cnt_r;
  hsd_pkg::count_t                       cnt_nxt;

  logic        out_valid_r;
  logic [15:0] out_code_r;
  logic        out_last_r;
  logic        out_bad_r;

  // refill the run buffer as soon as it drains to its last entry
  assign load   = in_vld_r && (cnt_r <= 3'd1);
  assign pop    = (cnt_r != 3'd0);
  assign busy   = in_vld_r && !load;
  assign accept = start && !busy;

  assign cap_rel  = 14'(in_code_point - hsd_pkg::SYL_BASE);
  assign cap_prod = 28'(cap_rel) * 28'(hsd_pkg::RECIP28);

  assign in_vld_nxt = accept ? 1'b1 : (load ? 1'b0 : in_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_code_r <= in_code_point;
      in_q28_r  <= cap_prod[hsd_pkg::SHIFT28 +: 9];
    end
  end

  hsd_decode u_decode (
    .code (in_code_r),
    .q28  (in_q28_r),
    .dec  (dec)
  );

  always_comb begin
    buf_nxt     = buf_r;
    buf_bad_nxt = buf_bad_r;
    cnt_nxt     = cnt_r;
    if (load) begin
      buf_nxt     = dec.codes;
      buf_bad_nxt = dec.bad;
      cnt_nxt     = dec.count;
    end else if (pop) begin
      // advance the run by one jamo
      buf_nxt[0] = buf_r[1];
      buf_nxt[1] = buf_r[2];
      buf_nxt[2] = buf_r[3];
      cnt_nxt    = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r     <= buf_nxt;
    buf_bad_r <= buf_bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_code_r <= buf_r[0];
      out_last_r <= (cnt_r == 3'd1);
      out_bad_r  <= buf_bad_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_jamo_code    = out_code_r;
  assign out_last_of_run  = out_last_r;
  assign out_bad_syllable = out_bad_r;

`ifndef ASSERT_OFF
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |=> out_valid_r)
    else $error("result run broken before its last transaction");

  a_bad_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_last_r && (out_code_r == 16'h0000))
    else $error("bad syllable result not a single zero transaction");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(hsd_pkg::MAX_RESULTS))
    else $error("run buffer count out of range");

  a_no_refill_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && (cnt_r > 3'd1) |=> in_vld_r && ($past(cnt_r) - 3'd1 == cnt_r))
    else $error("pending item dropped while run buffer busy");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT    = 200000;
  localparam int unsigned RANDOM_ITEMS = 390;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned SYL_PER_LEAD = 588;
  localparam int unsigned SYL_PER_VOWEL = 28;

  localparam hsd_pkg::code_t LEAD_TAB [19] = '{
    16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138, 16'h3139, 16'h3141,
    16'h3142, 16'h3143, 16'h3145, 16'h3146, 16'h3147, 16'h3148, 16'h3149,
    16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E
  };

  localparam hsd_pkg::code_t TAIL_TAB [27] = '{
    16'h3131, 16'h3132, 16'h3133, 16'h3134, 16'h3135, 16'h3136, 16'h3137,
    16'h3139, 16'h313A, 16'h313B, 16'h313C, 16'h313D, 16'h313E, 16'h313F,
    16'h3140, 16'h3141, 16'h3142, 16'h3144, 16'h3145, 16'h3146, 16'h3147,
    16'h3148, 16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E
  };

  // compound vowels: leading and trailing simple vowel, zero for a simple one
  localparam hsd_pkg::code_t VOWEL_HEAD [21] = '{
    16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
    16'h3157, 16'h3157, 16'h3157, 16'h0, 16'h0, 16'h315C, 16'h315C, 16'h315C,
    16'h0, 16'h0, 16'h3161, 16'h0
  };
  localparam hsd_pkg::code_t VOWEL_TAIL [21] = '{
    16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
    16'h314F, 16'h3150, 16'h3163, 16'h0, 16'h0, 16'h3153, 16'h3154, 16'h3163,
    16'h0, 16'h0, 16'h3163, 16'h0
  };

  typedef struct {
    hsd_pkg::code_t cp;
    int unsigned    gap;
  } char_item_t;

  typedef struct {
    hsd_pkg::code_t jamo;
    logic           last;
    logic           bad;
  } jamo_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  hsd_pkg::code_t in_code_point = '0;
  logic           busy;
  logic           out_valid;
  hsd_pkg::code_t out_jamo_code;
  logic           out_last_of_run;
  logic           out_bad_syllable;

  char_item_t  pending_chars[$];
  jamo_t       jamo_expected[$];
  logic        taken = 1'b0;
  int unsigned idle_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  hangul_syllable_decomposer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_code_point    (in_code_point),
    .out_valid        (out_valid),
    .out_jamo_code    (out_jamo_code),
    .out_last_of_run  (out_last_of_run),
    .out_bad_syllable (out_bad_syllable)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic push_jamo(input hsd_pkg::code_t j, input logic last, input logic bad);
    jamo_t e;
    e.jamo = j;
    e.last = last;
    e.bad  = bad;
    jamo_expected = {jamo_expected, e};
  endtask

  // expected jamo sequence for one code point
  task automatic decompose_char(input hsd_pkg::code_t cp);
    int unsigned    rel, lead, vowel, tail;
    hsd_pkg::code_t mapped;
    if (cp >= hsd_pkg::COMPAT_LO && cp <= hsd_pkg::COMPAT_HI) begin
      push_jamo(cp, 1'b1, 1'b0);
    end else if (cp >= hsd_pkg::CJ_INITIAL && cp <= hsd_pkg::CONJ_HI) begin
      mapped = cp;
      if (cp <= hsd_pkg::CJ_INITIAL_HI)
        mapped = LEAD_TAB[5'(cp - hsd_pkg::CJ_INITIAL)];
      else if (cp >= hsd_pkg::CJ_MEDIAL && cp <= hsd_pkg::CJ_MEDIAL_HI)
        mapped = hsd_pkg::COMPAT_VOWEL0 + (cp - hsd_pkg::CJ_MEDIAL);
      else if (cp >= hsd_pkg::CJ_FINAL && cp <= hsd_pkg::CJ_FINAL_HI)
        mapped = TAIL_TAB[5'(cp - hsd_pkg::CJ_FINAL)];
      push_jamo(mapped, 1'b1, 1'b0);
    end else if (cp < hsd_pkg::SYL_BASE || cp > hsd_pkg::SYL_END) begin
      push_jamo(cp, 1'b1, 1'b0);
    end else if (cp > hsd_pkg::SYL_LAST_VALID) begin
      push_jamo('0, 1'b1, 1'b1);
    end else begin
      rel   = 32'(cp) - 32'(hsd_pkg::SYL_BASE);
      lead  = rel / SYL_PER_LEAD;
      vowel = (rel % SYL_PER_LEAD) / SYL_PER_VOWEL;
      tail  = rel % SYL_PER_VOWEL;
      push_jamo(LEAD_TAB[5'(lead)], 1'b0, 1'b0);
      if (VOWEL_HEAD[5'(vowel)] != '0) begin
        push_jamo(VOWEL_HEAD[5'(vowel)], 1'b0, 1'b0);
        push_jamo(VOWEL_TAIL[5'(vowel)], tail == 0, 1'b0);
      end else begin
        push_jamo(hsd_pkg::COMPAT_VOWEL0 + 16'(vowel), tail == 0, 1'b0);
      end
      if (tail != 0)
        push_jamo(TAIL_TAB[5'(tail - 1)], 1'b1, 1'b0);
    end
  endtask

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic hsd_pkg::code_t random_syllable();
    int unsigned lead, vowel, tail;
    int unsigned compounds [7] = '{9, 10, 11, 14, 15, 16, 19};
    lead  = $urandom_range(0, 18);
    vowel = ($urandom_range(0, 9) < 4) ? compounds[3'($urandom_range(0, 6))]
                                       : $urandom_range(0, 20);
    tail  = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 27);
    return 16'(32'(hsd_pkg::SYL_BASE) + lead * SYL_PER_LEAD +
               vowel * SYL_PER_VOWEL + tail);
  endfunction

  function automatic hsd_pkg::code_t random_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return random_syllable();
    if (r < 55)
      return 16'($urandom_range(32'(hsd_pkg::SYL_LAST_VALID) + 1,
                                32'(hsd_pkg::SYL_END)));
    if (r < 70)
      return 16'($urandom_range(32'(hsd_pkg::CJ_INITIAL), 32'(hsd_pkg::CONJ_HI)));
    if (r < 80)
      return 16'($urandom_range(32'(hsd_pkg::COMPAT_LO), 32'(hsd_pkg::COMPAT_HI)));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic queue_char(input hsd_pkg::code_t cp, input int unsigned idx);
    char_item_t it;
    it.cp  = cp;
    // every so often run a stretch back to back
    it.gap = (idx % 50 < 10) ? 0 : draw_gap();
    pending_chars = {pending_chars, it};
  endtask

  // driver: change inputs on the falling edge, hold start until accepted
  always @(negedge clk) begin : drive_chars
    char_item_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // hold the transaction
    end else if (idle_left != 0) begin
      start     <= 1'b0;
      idle_left <= idle_left - 1;
    end else if (pending_chars.size() != 0) begin
      nxt = pending_chars.pop_front();
      start         <= 1'b1;
      in_code_point <= nxt.cp;
      idle_left     <= nxt.gap;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: check results, then predict for a newly accepted code point
  always @(posedge clk) begin : watch_jamo
    jamo_t e;
    cycles <= cycles + 1;
    if (out_valid && rst_n) begin
      if (jamo_expected.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected jamo %h last %b bad %b", out_jamo_code,
                   out_last_of_run, out_bad_syllable);
        mismatches <= mismatches + 1;
      end else begin
        e = jamo_expected.pop_front();
        if (out_jamo_code !== e.jamo || out_last_of_run !== e.last ||
            out_bad_syllable !== e.bad) begin
          if (mismatches < 10)
            $display("jamo mismatch: expected %h/%b/%b, got %h/%b/%b",
                     e.jamo, e.last, e.bad, out_jamo_code, out_last_of_run,
                     out_bad_syllable);
          mismatches <= mismatches + 1;
        end
      end
    end
    taken <= rst_n && start && !busy;
    if (rst_n && start && !busy)
      decompose_char(in_code_point);
  end

  always @(posedge clk) begin
    if (cycles >= RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    hsd_pkg::code_t directed [22] = '{
      16'h0000, 16'hFFFF, 16'h3130, 16'h318F, 16'h1100, 16'h1112, 16'h1113,
      16'h1161, 16'h1175, 16'h11A8, 16'h11C2, 16'h11C3, 16'h11FF, 16'hABFF,
      16'hAC00, 16'hAC01, 16'hD7A3, 16'hD7A4, 16'hD7AF, 16'hD7B0,
      16'(16'hAC00 + 9 * 28), 16'(16'hAC00 + 18 * 588 + 19 * 28 + 27)
    };
    int unsigned n;
    n = 0;
    foreach (directed[i]) begin
      queue_char(directed[i], n);
      n++;
    end
    repeat (RANDOM_ITEMS) begin
      queue_char(random_char(), n);
      n++;
    end

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    wait (pending_chars.size() == 0);
    @(posedge clk);
    while (start || jamo_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && jamo_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
